// ===== sv/pfs_pkg.sv =====
// Shared types and constants for the pixel fade step block.
// No dependencies; compiled first.
package pfs_pkg;

    localparam int VALUE_W    = 8;
    localparam int DURATION_W = 16;
    localparam int BYTE_MAX   = 255;
    localparam int BYTE_SIZE  = 256;
    localparam int STEP_MS    = 20;

    // Durations at or above this saturate the step total at BYTE_MAX
    localparam int SAT_DURATION = STEP_MS * BYTE_SIZE;

    // duration / 20 == (duration * 0xCCCD) >> 20 for every 16-bit duration
    localparam int DIV20_RECIP = 52429;
    localparam int DIV20_SHIFT = 20;

    // One quotient bit per divider iteration
    localparam int DIV_STEPS = VALUE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WB
    } t_pfs_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic iterate;
        logic commit;
    } t_pfs_cmd;

endpackage

// ===== sv/pfs_if.sv =====
// Valid/ready channel interfaces for the input and result words.
// Depends on pfs_pkg for field widths.
interface pfs_in_if;
    logic                           valid;
    logic                           ready;
    logic [pfs_pkg::VALUE_W-1:0]    current_value;
    logic [pfs_pkg::VALUE_W-1:0]    target_value;
    logic                           enabled;
    logic                           frame_last;

    modport source (output valid, current_value, target_value, enabled, frame_last,
                    input ready);
    modport sink   (input valid, current_value, target_value, enabled, frame_last,
                    output ready);
endinterface

interface pfs_out_if;
    logic                           valid;
    logic                           ready;
    logic [pfs_pkg::VALUE_W-1:0]    new_value;
    logic                           finished;

    modport source (output valid, new_value, finished, input ready);
    modport sink   (input valid, new_value, finished, output ready);
endinterface

// ===== sv/pfs_ctrl.sv =====
// Controller state machine: sequences load, divide iterations and write-back.
// Depends on pfs_pkg for the state enum and command struct.
module pfs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output pfs_pkg::t_pfs_cmd   o_cmd
);
    import pfs_pkg::*;

    t_pfs_state         r_state;
    t_pfs_state         n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DIV: begin
                o_cmd.iterate = 1'b1;
            end
            ST_WB: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Hold the result word until it is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/pfs_dp.sv =====
// Datapath: step counter, step total, restoring divider and output register.
// Depends on pfs_pkg; driven by commands from pfs_ctrl.
module pfs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pfs_pkg::t_pfs_cmd               i_cmd,
    input  logic                            i_cfg_we,
    input  logic [pfs_pkg::DURATION_W-1:0]  i_cfg_wdata,
    input  logic [pfs_pkg::VALUE_W-1:0]     i_current_value,
    input  logic [pfs_pkg::VALUE_W-1:0]     i_target_value,
    input  logic                            i_enabled,
    input  logic                            i_frame_last,
    output logic [pfs_pkg::VALUE_W-1:0]     o_new_value,
    output logic                            o_finished
);
    import pfs_pkg::*;

    localparam int PROD_W = 2 * DURATION_W;

    logic [VALUE_W-1:0]     r_total;
    logic [VALUE_W-1:0]     r_step;
    logic [VALUE_W-1:0]     n_step;
    logic [VALUE_W-1:0]     n_total_cfg;
    logic [PROD_W-1:0]      cfg_prod;

    logic                   neg;
    logic [VALUE_W-1:0]     mag;
    logic [VALUE_W-1:0]     remaining;
    logic                   quot_case;

    logic [VALUE_W-1:0]     r_cur;
    logic                   r_neg;
    logic                   r_move;
    logic                   r_quot_case;
    logic                   r_fin;
    logic [VALUE_W-1:0]     r_quo;
    logic [VALUE_W-1:0]     r_rem;
    logic [VALUE_W-1:0]     r_dvs;
    logic [VALUE_W:0]       shifted;
    logic [VALUE_W:0]       trial;
    logic                   fits;
    logic [VALUE_W-1:0]     move_amt;
    logic [VALUE_W-1:0]     n_value;
    logic [VALUE_W-1:0]     r_out_value;
    logic                   r_out_fin;

    // Step total from the written duration: saturate, else divide by 20
    assign cfg_prod = PROD_W'(i_cfg_wdata) * PROD_W'(DIV20_RECIP);
    always_comb begin
        if (i_cfg_wdata >= DURATION_W'(SAT_DURATION)) begin
            n_total_cfg = VALUE_W'(BYTE_MAX);
        end else begin
            n_total_cfg = cfg_prod[DIV20_SHIFT +: VALUE_W];
        end
    end

    // Advance step, saturating at the top
    assign n_step = (r_step == VALUE_W'(BYTE_MAX)) ? r_step : r_step + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= VALUE_W'(BYTE_MAX);
            r_step  <= '0;
        end else if (i_cfg_we) begin
            r_total <= n_total_cfg;
            r_step  <= '0;
        end else if (i_cmd.load && i_frame_last) begin
            r_step  <= n_step;
        end
    end

    // Distance, steps left, and which division the word needs
    assign neg       = i_current_value > i_target_value;
    assign mag       = neg ? i_current_value - i_target_value
                           : i_target_value - i_current_value;
    assign remaining = (r_total > r_step) ? r_total - r_step : VALUE_W'(1);
    assign quot_case = remaining <= mag;

    // One restoring divide step
    assign shifted = {r_rem, r_quo[VALUE_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur       <= i_current_value;
            r_neg       <= neg;
            r_move      <= i_enabled && (mag != '0);
            r_quot_case <= quot_case;
            r_fin       <= i_frame_last && (n_step >= r_total);
            r_quo       <= quot_case ? mag : remaining;
            r_dvs       <= quot_case ? remaining : mag;
            r_rem       <= '0;
        end else if (i_cmd.iterate) begin
            r_quo <= {r_quo[VALUE_W-2:0], fits};
            r_rem <= fits ? trial[VALUE_W-1:0] : shifted[VALUE_W-1:0];
        end
    end

    // Quotient moves directly; otherwise one unit when the remainder is zero
    always_comb begin
        if (r_quot_case) begin
            move_amt = r_quo;
        end else begin
            move_amt = VALUE_W'(r_rem == '0);
        end
        if (!r_move) begin
            n_value = r_cur;
        end else if (r_neg) begin
            n_value = r_cur - move_amt;
        end else begin
            n_value = r_cur + move_amt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_value <= n_value;
            r_out_fin   <= r_fin;
        end
    end

    assign o_new_value = r_out_value;
    assign o_finished  = r_out_fin;

endmodule

// ===== sv/pixel_fade_step.sv =====
// Pixel fade step top level: one channel word in, one faded word out.
// Each word is accepted, then runs the divider, one iteration per quotient bit,
// then write-back; the next word is accepted only after write-back, which waits
// while the previous result has not been taken.
// Synchronous active-low reset: step counter 0, step total 255
// (duration 5120), no result pending. Depends on pfs_pkg, pfs_if, pfs_ctrl, pfs_dp.
module pixel_fade_step (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pfs_pkg::DURATION_W-1:0]  i_cfg_wdata,
    pfs_in_if.sink                          i_in,
    pfs_out_if.source                       o_out
);
    import pfs_pkg::*;

    t_pfs_cmd cmd;

    // Sequence each word
    pfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // Compute the faded value and step state
    pfs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_current_value (i_in.current_value),
        .i_target_value  (i_in.target_value),
        .i_enabled       (i_in.enabled),
        .i_frame_last    (i_in.frame_last),
        .o_new_value     (o_out.new_value),
        .o_finished      (o_out.finished)
    );

`ifndef SYNTH
    // Only one word in flight: no accept right after an accept
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while divider busy");

    // Write-back always presents a result next cycle
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out.valid)
        else $error("commit did not raise result valid");

    // Divider never runs while the input side is open, nor alongside a load or commit
    a_iter_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.iterate |-> (!i_in.ready && !cmd.load && !cmd.commit))
        else $error("divider iteration overlaps load or commit");

    // A pending result that is not taken is never overwritten
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !cmd.commit)
        else $error("result overwritten while stalled");
`endif

endmodule

// ===== tb/sv/pfs_fade_checker.sv =====
// Scoreboard for pixel_fade_step: tracks the duration writes and the step counter,
// predicts each faded word and compares it with the block's result words.
// Depends on pfs_pkg and the channel interfaces in pfs_if.
`timescale 1ns / 100ps

module pfs_fade_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfs_pkg::DURATION_W-1:0] i_cfg_wdata,
    pfs_in_if                              i_in,
    pfs_out_if                             i_out,
    output int                             o_err_count,
    output int                             o_pending
);
    import pfs_pkg::*;

    localparam int                  FADE_STEP_CAP    = 255;
    localparam int                  MS_PER_STEP      = 20;
    localparam int                  CAP_DURATION     = 5120;
    localparam logic [DURATION_W-1:0] RESET_DURATION = 16'd5120;

    typedef struct packed {
        logic [VALUE_W-1:0] new_value;
        logic               finished;
    } t_fade_word;

    t_fade_word              fade_q[$];
    logic [DURATION_W-1:0]   duration_r;
    logic [7:0]              step_r;
    int                      err_cnt = 0;

    // Number of steps a fade of the given length in ms is split into
    function automatic int fade_steps(input logic [DURATION_W-1:0] dur);
        if (int'(dur) >= CAP_DURATION) return FADE_STEP_CAP;
        return int'(dur) / MS_PER_STEP;
    endfunction

    // Move one channel toward its target with the given number of steps left
    function automatic logic [VALUE_W-1:0] faded_value(input logic [VALUE_W-1:0] cur,
                                                       input logic [VALUE_W-1:0] tgt,
                                                       input int                 left);
        int delta;
        int mag;
        int val;
        delta = int'(tgt) - int'(cur);
        mag   = (delta < 0) ? -delta : delta;
        val   = int'(cur);
        if (delta != 0) begin
            if (left <= mag) begin
                val = val + delta / left;
            end else if (left % mag == 0) begin
                val = val + ((delta < 0) ? -1 : 1);
            end
        end
        return val[VALUE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        int         left;
        t_fade_word due;
        if (!i_rst_n) begin
            fade_q.delete();
            duration_r = RESET_DURATION;
            step_r     = '0;
        end else begin
            // compare a result word with the oldest expectation
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                if (fade_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected word: expected none, got new_value=%0d finished=%0b",
                             $time, i_out.new_value, i_out.finished);
                end else begin
                    due = fade_q.pop_front();
                    if (i_out.new_value !== due.new_value) begin
                        err_cnt++;
                        $display("%0t: new_value mismatch: expected %0d, got %0d",
                                 $time, due.new_value, i_out.new_value);
                    end
                    if (i_out.finished !== due.finished) begin
                        err_cnt++;
                        $display("%0t: finished mismatch: expected %0b, got %0b",
                                 $time, due.finished, i_out.finished);
                    end
                end
            end

            // a duration write restarts the fade
            if (i_cfg_we) begin
                duration_r = i_cfg_wdata;
                step_r     = '0;
            end

            // predict the word for each accepted input word
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                left = fade_steps(duration_r) - int'(step_r);
                if (left <= 0) left = 1;
                due.new_value = i_in.enabled ? faded_value(i_in.current_value,
                                                           i_in.target_value, left)
                                             : i_in.current_value;
                due.finished = 1'b0;
                if (i_in.frame_last) begin
                    if (int'(step_r) < FADE_STEP_CAP) step_r = step_r + 8'd1;
                    if (int'(step_r) >= fade_steps(duration_r)) due.finished = 1'b1;
                end
                fade_q.push_back(due);
            end
        end
        o_err_count <= err_cnt;
        o_pending   <= fade_q.size();
    end

endmodule

// ===== tb/sv/tb_pixel_fade_step.sv =====
// Testbench top for pixel_fade_step: clock, reset, duration writes, input words
// with random bursts and output stalls; checking is done by pfs_fade_checker.
// Depends on pfs_pkg, pfs_if, pixel_fade_step and pfs_fade_checker.
`timescale 1ns / 100ps

module tb_pixel_fade_step;
    import pfs_pkg::*;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PULSE
    } t_rx_mode;

    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_1    = 1500;
    localparam int HOLD_AT_2    = 12000;
    localparam int SETTLE_WAIT  = 12;
    localparam int DRAIN_LIMIT  = 20000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [DURATION_W-1:0] cfg_wdata = '0;

    int err_count;
    int pending;
    int words_sent  = 0;
    int frame_ends  = 0;
    int cfg_writes  = 0;
    int burst_left  = 0;
    int holds_done  = 0;

    pfs_in_if  in_ch ();
    pfs_out_if out_ch ();

    pixel_fade_step u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    pfs_fade_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop in case the handshake hangs
    initial begin
        #5_000_000;
        $display("Timeout with %0d words still expected", pending);
        $display("DONE: errors detected");
        $finish;
    end

    // offer one word; may idle first when a burst has run out
    task automatic offer(input logic [VALUE_W-1:0] cur, input logic [VALUE_W-1:0] tgt,
                         input logic en, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid         <= 1'b0;
                in_ch.current_value <= VALUE_W'($urandom);
                in_ch.target_value  <= VALUE_W'($urandom);
                in_ch.enabled       <= 1'($urandom);
                in_ch.frame_last    <= 1'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.current_value <= cur;
        in_ch.target_value  <= tgt;
        in_ch.enabled       <= en;
        in_ch.frame_last    <= last;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        words_sent++;
        if (last) frame_ends++;
    endtask

    // drain the block, then write a new duration
    task automatic set_duration(input logic [DURATION_W-1:0] dur);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= dur;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= DURATION_W'($urandom);
        burst_left = 0;
        cfg_writes++;
    endtask

    // one duration setting followed by framed words with random content
    task automatic run_phase(input logic [DURATION_W-1:0] dur, input int count,
                             input int max_frame);
        int               frame_left;
        int               pick;
        logic [VALUE_W-1:0] cur;
        logic [VALUE_W-1:0] tgt;
        logic             en;
        logic             last;
        set_duration(dur);
        frame_left = $urandom_range(1, max_frame);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            cur  = VALUE_W'($urandom);
            if (pick < 6) begin
                tgt = VALUE_W'($urandom);
            end else if (pick < 8) begin
                tgt = cur + VALUE_W'($urandom_range(0, 16)) - VALUE_W'(8);
            end else if (pick == 8) begin
                cur = $urandom_range(0, 1) ? '1 : '0;
                tgt = $urandom_range(0, 1) ? '1 : '0;
            end else begin
                tgt = cur;
            end
            en = ($urandom_range(0, 7) != 0);
            // mostly well-formed frames, a few stray frame ends
            if ($urandom_range(0, 19) == 0) begin
                last = 1'($urandom);
            end else begin
                frame_left--;
                last = (frame_left == 0);
                if (last) frame_left = $urandom_range(1, max_frame);
            end
            offer(cur, tgt, en, last);
        end
    endtask

    // receiver: random stall patterns plus long hold-offs
    initial begin : rx_stall
        int       cyc;
        int       mode_left;
        int       hold_left;
        t_rx_mode mode;
        cyc       = 0;
        mode_left = 0;
        hold_left = 0;
        mode      = RX_OPEN;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n) begin
                cyc++;
                if (cyc == HOLD_AT_1 || cyc == HOLD_AT_2) begin
                    hold_left = HOLD_CYCLES;
                    holds_done++;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    out_ch.ready <= 1'b0;
                end else begin
                    if (mode_left == 0) begin
                        mode      = t_rx_mode'($urandom_range(0, 3));
                        mode_left = $urandom_range(50, 300);
                    end
                    mode_left--;
                    case (mode)
                        RX_OPEN:   out_ch.ready <= 1'b1;
                        RX_COIN:   out_ch.ready <= 1'($urandom);
                        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 9) == 0);
                        default:   out_ch.ready <= (cyc % 4 == 0);
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        int drain;
        in_ch.valid         <= 1'b0;
        in_ch.current_value <= '0;
        in_ch.target_value  <= '0;
        in_ch.enabled       <= 1'b0;
        in_ch.frame_last    <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset duration: 255 steps, fade starts at step 0
        offer(8'd0,   8'd255, 1'b1, 1'b0);
        offer(8'd255, 8'd0,   1'b1, 1'b0);
        offer(8'd128, 8'd128, 1'b1, 1'b0);
        offer(8'd0,   8'd255, 1'b0, 1'b0);
        offer(8'd0,   8'd1,   1'b1, 1'b0);
        offer(8'd0,   8'd2,   1'b1, 1'b0);
        offer(8'd200, 8'd197, 1'b1, 1'b0);
        offer(8'd0,   8'd17,  1'b1, 1'b0);
        offer(8'd10,  8'd0,   1'b1, 1'b0);
        offer(8'd255, 8'd255, 1'b1, 1'b1);
        offer(8'd0,   8'd127, 1'b1, 1'b0);
        offer(8'd0,   8'd254, 1'b1, 1'b1);

        // zero step total: jump to target, finished on the first frame end
        set_duration(16'd0);
        offer(8'd0,   8'd255, 1'b1, 1'b0);
        offer(8'd255, 8'd0,   1'b1, 1'b0);
        offer(8'd77,  8'd3,   1'b0, 1'b1);
        offer(8'd5,   8'd200, 1'b1, 1'b1);

        // single step, then past the total
        set_duration(16'd20);
        offer(8'd0,   8'd255, 1'b1, 1'b1);
        offer(8'd40,  8'd90,  1'b1, 1'b1);

        run_phase(16'hFFFF, 200, 3);
        run_phase(16'd19,    40, 2);
        run_phase(16'd0,     40, 3);
        run_phase(16'd100,  150, 4);
        // one word per frame so the step counter reaches its top
        run_phase(16'd5119, 350, 1);
        for (int p = 0; p < 6; p++) begin
            run_phase(DURATION_W'($urandom_range(20, 1200)), 120, 6);
        end
        run_phase(DURATION_W'($urandom), 60, 8);
        run_phase(16'd5120, 150, 12);

        // wait for the last results
        in_ch.valid <= 1'b0;
        @(posedge clk);
        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);

        if (pending != 0) $display("%0d expected words never arrived", pending);
        $display("Sent %0d words with %0d frame ends over %0d duration writes",
                 words_sent, frame_ends, cfg_writes);
        $display("Durations from zero to full scale; %0d long output hold-offs", holds_done);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/pfs_pkg.sv
sv/pfs_if.sv
sv/pfs_ctrl.sv
sv/pfs_dp.sv
sv/pixel_fade_step.sv
tb/sv/pfs_fade_checker.sv
tb/sv/tb_pixel_fade_step.sv
